[hdl/pcd_pkg.sv]
// Shared types and constants for the phase clock with divisions.
// Used by pcd_cfg_regs, pcd_tick and phase_clock_with_divisions; no dependencies.
package pcd_pkg;

    localparam int unsigned PHASE_W = 32;
    localparam int unsigned LEN_W   = 20;
    localparam int unsigned THR_W   = 17;
    localparam int unsigned RND_W   = 16;
    localparam int unsigned STEP_W  = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAND_THR   = 2'd3;

    // Values after reset.
    localparam logic [PHASE_W-1:0] PHASE_INC_RST = 32'd4473924;
    localparam logic [LEN_W-1:0]   GATE_LEN_RST  = 20'd240;
    localparam logic [LEN_W-1:0]   RESET_LEN_RST = 20'd480;
    localparam logic [THR_W-1:0]   RAND_THR_RST  = 17'd0;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_inc;
        logic [LEN_W-1:0]   gate_len;
        logic [LEN_W-1:0]   reset_len;
        logic [THR_W-1:0]   rand_thr;
    } t_cfg;

    typedef struct packed {
        logic clock_gate;
        logic reset_gate;
        logic div4_gate;
        logic div8_gate;
        logic div16_gate;
        logic div32_gate;
        logic running_flag;
    } t_gates;

endpackage

[hdl/pcd_cfg_regs.sv]
// Configuration register file of the phase clock with divisions.
// Depends on pcd_pkg for register indexes, reset values and the t_cfg type.
module pcd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output pcd_pkg::t_cfg                 o_cfg
);
    import pcd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PHASE_INC: n_cfg.phase_inc = i_cfg_data[PHASE_W-1:0];
                CFG_GATE_LEN:  n_cfg.gate_len  = i_cfg_data[LEN_W-1:0];
                CFG_RESET_LEN: n_cfg.reset_len = i_cfg_data[LEN_W-1:0];
                CFG_RAND_THR:  n_cfg.rand_thr  = i_cfg_data[THR_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_inc <= PHASE_INC_RST;
            r_cfg.gate_len  <= GATE_LEN_RST;
            r_cfg.reset_len <= RESET_LEN_RST;
            r_cfg.rand_thr  <= RAND_THR_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/pcd_tick.sv]
// Per-tick state update of the phase clock: button edges, phase accumulator,
// step count and pulse counters. Depends on pcd_pkg.
module pcd_tick (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  logic                      i_run_button,
    input  logic                      i_reset_button,
    input  logic [pcd_pkg::RND_W-1:0] i_random_word,
    input  pcd_pkg::t_cfg             i_cfg,
    output pcd_pkg::t_gates           o_gates
);
    import pcd_pkg::*;

    logic               r_running, n_running;
    logic               r_run_seen, r_rst_seen;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [STEP_W-1:0]  r_steps, n_steps;
    logic [LEN_W-1:0]   r_gate_rem, n_gate_rem;
    logic [LEN_W-1:0]   r_rst_rem, n_rst_rem;

    logic               run_edge;
    logic               restart;
    logic               step;
    logic               rand_hit;
    logic [PHASE_W:0]   phase_sum;
    logic [PHASE_W-1:0] phase_base;
    logic [STEP_W-1:0]  steps_base;
    logic [LEN_W-1:0]   gate_armed;
    logic [LEN_W-1:0]   rst_armed;
    logic               gate_on;
    logic               rst_on;

    always_comb begin
        run_edge  = i_run_button && !r_run_seen;
        n_running = run_edge ? !r_running : r_running;
        // Starting to run, or a reset edge, restarts the clock.
        restart   = (run_edge && n_running) || (i_reset_button && !r_rst_seen);

        phase_base = restart ? '0 : r_phase;
        steps_base = restart ? '0 : r_steps;
        phase_sum  = {1'b0, phase_base} + {1'b0, i_cfg.phase_inc};
        step       = n_running && phase_sum[PHASE_W];
        rand_hit   = {1'b0, i_random_word} < i_cfg.rand_thr;

        n_phase = n_running ? phase_sum[PHASE_W-1:0] : phase_base;
        n_steps = step ? steps_base + STEP_W'(1) : steps_base;

        // Restart and random reset both arm with the same length.
        rst_armed  = ((restart || (step && rand_hit)) && (i_cfg.reset_len > r_rst_rem))
                     ? i_cfg.reset_len : r_rst_rem;
        gate_armed = (step && (i_cfg.gate_len > r_gate_rem)) ? i_cfg.gate_len : r_gate_rem;

        gate_on = n_running && (gate_armed != '0);
        rst_on  = n_running && (rst_armed != '0);

        n_gate_rem = gate_on ? gate_armed - LEN_W'(1) : gate_armed;
        n_rst_rem  = rst_on ? rst_armed - LEN_W'(1) : rst_armed;
    end

    always_comb begin
        o_gates.clock_gate   = gate_on;
        o_gates.reset_gate   = rst_on;
        o_gates.div4_gate    = gate_on && (n_steps[1:0] == '0);
        o_gates.div8_gate    = gate_on && (n_steps[2:0] == '0);
        o_gates.div16_gate   = gate_on && (n_steps[3:0] == '0);
        o_gates.div32_gate   = gate_on && (n_steps[4:0] == '0);
        o_gates.running_flag = n_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= 1'b1;
            r_run_seen <= 1'b1;
            r_rst_seen <= 1'b1;
            r_phase    <= '0;
            r_steps    <= '0;
            r_gate_rem <= '0;
            r_rst_rem  <= '0;
        end else if (i_fire) begin
            r_running  <= n_running;
            r_run_seen <= i_run_button;
            r_rst_seen <= i_reset_button;
            r_phase    <= n_phase;
            r_steps    <= n_steps;
            r_gate_rem <= n_gate_rem;
            r_rst_rem  <= n_rst_rem;
        end
    end

    // No tick, no change of clock state.
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_phase) && $stable(r_steps) && $stable(r_gate_rem)
                     && $stable(r_rst_rem) && $stable(r_running)))
        else $error("clock state changed without a tick");

    // A stopped clock holds its gate counter.
    a_stopped_gate_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !n_running) |=> $stable(r_gate_rem))
        else $error("gate counter moved while stopped");

    // The gate counter only holds, counts down by one, or restarts from the gate length.
    a_gate_rem_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |=> ((r_gate_rem == $past(r_gate_rem))
                    || (r_gate_rem == $past(r_gate_rem) - LEN_W'(1))
                    || (r_gate_rem == $past(i_cfg.gate_len) - LEN_W'(1))))
        else $error("gate counter took an unexpected value");

endmodule

[hdl/phase_clock_with_divisions.sv]
// Top level of the phase clock with divisions: request and result registers
// around the tick logic. Depends on pcd_pkg, pcd_cfg_regs and pcd_tick.
//
// Usage. Each request on the input channel is one sample tick carrying the
// run and reset button levels and a random word; it is taken at a rising
// edge where i_in_valid is high and o_in_stall is low. Every request yields
// exactly one result on the output channel: the clock and reset gates, the
// divide-by-4, 8, 16 and 32 gates and the running flag, taken where
// o_out_valid is high and i_out_stall is low.
// A request is held in the request register, the tick logic works out its
// state update and result, and the result appears from the result register.
// Throughput is one request per cycle while the receiver does not stall, set
// by the combinational phase add and pulse counter update in pcd_tick; a
// request is taken even while a finished result waits, as long as the result
// register can move on in the same cycle.
// When the receiver stalls, the result holds, the request register fills and
// then o_in_stall rises until the result is taken.
// Reset (synchronous, active low) sets the configuration registers to their
// defaults, empties both registers, and starts the clock in the running
// state with both button levels treated as already high, so a button held
// high through reset gives no edge until it has been released.
// Configuration writes take effect at once and are meant for an idle block.
module phase_clock_with_divisions (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_run_button,
    input  logic                           i_reset_button,
    input  logic [pcd_pkg::RND_W-1:0]      i_random_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_clock_gate,
    output logic                           o_reset_gate,
    output logic                           o_div4_gate,
    output logic                           o_div8_gate,
    output logic                           o_div16_gate,
    output logic                           o_div32_gate,
    output logic                           o_running_flag
);
    import pcd_pkg::*;

    t_cfg   cfg;
    t_gates gates;

    // Request register.
    logic             r_in_vld;
    logic             r_run_btn;
    logic             r_rst_btn;
    logic [RND_W-1:0] r_rnd;

    // Result register.
    logic   r_out_vld;
    t_gates r_out;

    logic out_en;
    logic in_en;
    logic fire;

    // The result register may load when it is empty or its result is taken now;
    // the request register may load when it is empty or moves on now.
    assign out_en     = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && out_en;
    assign in_en      = !r_in_vld || out_en;
    assign o_in_stall = !in_en;

    pcd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pcd_tick u_tick (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_run_button   (r_run_btn),
        .i_reset_button (r_rst_btn),
        .i_random_word  (r_rnd),
        .i_cfg          (cfg),
        .o_gates        (gates)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_en) begin
            r_in_vld <= i_in_valid;
        end
    end

    // The payload loads only with a new request, so it needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_en && i_in_valid) begin
            r_run_btn <= i_run_button;
            r_rst_btn <= i_reset_button;
            r_rnd     <= i_random_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_en) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= gates;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_clock_gate   = r_out.clock_gate;
    assign o_reset_gate   = r_out.reset_gate;
    assign o_div4_gate    = r_out.div4_gate;
    assign o_div8_gate    = r_out.div8_gate;
    assign o_div16_gate   = r_out.div16_gate;
    assign o_div32_gate   = r_out.div32_gate;
    assign o_running_flag = r_out.running_flag;

endmodule
